/* rtl/uces_pkg.sv */
package uces_pkg;

	localparam int MaxRow = 4096;
	localparam int ColBits = 12;
	localparam int ValBits = 32;
	localparam int RhoBits = 31;
	localparam int GainBits = 31;
	localparam int RegIdxBits = 2;
	localparam int CfgBits = 31;
	localparam int FifoDepth = 2;

	localparam logic [RegIdxBits-1:0] REG_ROW_WIDTH = 2'd0;
	localparam logic [RegIdxBits-1:0] REG_GAIN_X = 2'd1;
	localparam logic [RegIdxBits-1:0] REG_GAIN_Y = 2'd2;

	localparam logic [16:0] HalfW = 17'd32768;
	localparam logic [16:0] OneW = 17'd65536;

	typedef struct packed {
		logic signed [ValBits-1:0] flux_b;
		logic signed [ValBits-1:0] emf;
		logic [RhoBits-1:0] rho;
		logic signed [ValBits-1:0] mflux;
	} cell_rec_t;

	typedef struct packed {
		logic signed [ValBits-1:0] flux_b;
		logic signed [ValBits-1:0] emf;
		logic [RhoBits-1:0] rho;
		logic signed [ValBits-1:0] mflux;
	} row_rec_t;

	typedef struct packed {
		logic signed [ValBits:0] e1j;
		logic signed [ValBits:0] e1jm;
		logic signed [ValBits-1:0] e2i;
		logic signed [ValBits-1:0] e2im;
		logic signed [ValBits-1:0] cc;
		logic signed [ValBits-1:0] cl;
		logic signed [ValBits-1:0] ca;
		logic signed [ValBits-1:0] cbl;
		logic signed [ValBits-1:0] flux0;
		logic signed [ValBits-1:0] flux1;
		logic signed [ValBits-1:0] flux2;
		logic signed [ValBits-1:0] flux3;
		logic [RhoBits:0] den0;
		logic [RhoBits:0] den1;
		logic [RhoBits:0] den2;
		logic [RhoBits:0] den3;
		logic [GainBits-1:0] gain_x;
		logic [GainBits-1:0] gain_y;
		logic [ColBits-1:0] col;
		logic [ColBits-1:0] row;
	} job_t;

	typedef enum logic [1:0] {
		FE_TAKE,
		FE_MUL,
		FE_EMF,
		FE_EMIT
	} fe_state_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MUL,
		BK_DIV,
		BK_ACC,
		BK_OUT
	} bk_state_t;

	function automatic logic signed [ValBits-1:0] sat_val(input logic signed [95:0] v);
		logic signed [95:0] vmax;
		logic signed [95:0] vmin;
		vmax = 96'sd2147483647;
		vmin = -96'sd2147483648;
		if (v > vmax) begin
			return 32'sh7fffffff;
		end else if (v < vmin) begin
			return 32'sh80000000;
		end
		return v[ValBits-1:0];
	endfunction

endpackage

/* rtl/uces_front.sv */
module uces_front import uces_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic sof,
	input  logic signed [ValBits-1:0] vel_x,
	input  logic signed [ValBits-1:0] vel_y,
	input  logic signed [ValBits-1:0] mag_x,
	input  logic signed [ValBits-1:0] mag_y,
	input  logic [RhoBits-1:0] density,
	input  logic signed [ValBits-1:0] xface_flux_of_by,
	input  logic signed [ValBits-1:0] yface_flux_of_bx,
	input  logic signed [ValBits-1:0] xface_mass_flux,
	input  logic signed [ValBits-1:0] yface_mass_flux,
	input  logic [12:0] row_width,
	input  logic [GainBits-1:0] gain_x,
	input  logic [GainBits-1:0] gain_y,
	output logic job_valid,
	input  logic job_ready,
	output job_t job
);

	// Phases: take item, products, cell emf + store read, emit job.
	fe_state_t ph_q, ph_d;
	logic emit_go;
	logic [ColBits-1:0] col_q, row_q;
	logic [ColBits-1:0] col_c, row_c;
	logic sof_s1;
	logic signed [ValBits-1:0] vx_s1, vy_s1, bx_s1, by_s1, fxb_s1, fyb_s1, mx_s1, my_s1;
	logic [RhoBits-1:0] rho_s1;
	logic signed [63:0] p1_s2, p2_s2;
	logic signed [ValBits-1:0] emf_s3;
	row_rec_t row_mem [MaxRow];
	row_rec_t above_s3;
	cell_rec_t left_q;
	logic signed [ValBits-1:0] bl_emf_q;
	logic [RhoBits-1:0] bl_rho_q;
	logic [12:0] width_c;
	logic signed [64:0] diff;

	always_comb begin
		ph_d = ph_q;
		unique case (ph_q)
			FE_TAKE: if (in_valid) ph_d = FE_MUL;
			FE_MUL: ph_d = FE_EMF;
			FE_EMF: ph_d = FE_EMIT;
			FE_EMIT: if (!job_valid || job_ready) ph_d = FE_TAKE;
			default: ph_d = FE_TAKE;
		endcase
	end

	always_comb begin
		in_ready = (ph_q == FE_TAKE);
		job_valid = (ph_q == FE_EMIT) && (col_c != '0) && (row_c != '0);
		emit_go = (ph_q == FE_EMIT) && (!job_valid || job_ready);
	end

	always_comb begin
		col_c = sof_s1 ? '0 : col_q;
		row_c = sof_s1 ? '0 : row_q;
		if (row_width < 13'd2) begin
			width_c = 13'd2;
		end else if (row_width > 13'd4096) begin
			width_c = 13'd4096;
		end else begin
			width_c = row_width;
		end
		diff = 65'(p1_s2) - 65'(p2_s2);
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sof_s1 <= sof;
			vx_s1 <= vel_x; vy_s1 <= vel_y; bx_s1 <= mag_x; by_s1 <= mag_y;
			rho_s1 <= density; fxb_s1 <= xface_flux_of_by; fyb_s1 <= yface_flux_of_bx;
			mx_s1 <= xface_mass_flux; my_s1 <= yface_mass_flux;
		end
		if (ph_q == FE_MUL) begin
			p1_s2 <= vy_s1 * bx_s1;
			p2_s2 <= vx_s1 * by_s1;
		end
		if (ph_q == FE_EMF) begin
			emf_s3 <= sat_val(96'(diff >>> 16));
			above_s3 <= row_mem[col_c];
		end
		if (emit_go) begin
			row_mem[col_c] <= '{flux_b: fxb_s1, emf: emf_s3, rho: rho_s1, mflux: mx_s1};
			left_q <= '{flux_b: fyb_s1, emf: emf_s3, rho: rho_s1, mflux: my_s1};
			bl_emf_q <= above_s3.emf;
			bl_rho_q <= above_s3.rho;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= FE_TAKE;
			col_q <= '0;
			row_q <= '0;
		end else begin
			ph_q <= ph_d;
			if (emit_go) begin
				if (13'(col_c) + 13'd1 >= width_c) begin
					col_q <= '0;
					row_q <= row_c + 12'd1;
				end else begin
					col_q <= col_c + 12'd1;
					row_q <= row_c;
				end
			end
		end
	end

	always_comb begin
		job.e1j = -(33'(fxb_s1));
		job.e1jm = -(33'(above_s3.flux_b));
		job.e2i = fyb_s1;
		job.e2im = left_q.flux_b;
		job.cc = emf_s3;
		job.cl = left_q.emf;
		job.ca = above_s3.emf;
		job.cbl = bl_emf_q;
		job.flux0 = above_s3.mflux;
		job.den0 = 32'(bl_rho_q) + 32'(above_s3.rho);
		job.flux1 = mx_s1;
		job.den1 = 32'(left_q.rho) + 32'(rho_s1);
		job.flux2 = left_q.mflux;
		job.den2 = 32'(bl_rho_q) + 32'(left_q.rho);
		job.flux3 = my_s1;
		job.den3 = 32'(above_s3.rho) + 32'(rho_s1);
		job.gain_x = gain_x;
		job.gain_y = gain_y;
		job.col = col_c;
		job.row = row_c;
	end

	property p_no_edge_job;
		@(posedge clk) disable iff (!arst_n) job_valid |-> (job.col != '0 && job.row != '0);
	endproperty
	assert property (p_no_edge_job) else $error("job issued for column or row zero");

	property p_take;
		@(posedge clk) disable iff (!arst_n) in_valid && in_ready |=> ph_q == FE_MUL;
	endproperty
	assert property (p_take) else $error("accepted transaction not processed");

endmodule

/* rtl/uces_fifo.sv */
module uces_fifo import uces_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  job_t wr_data,
	output logic rd_valid,
	input  logic rd_ready,
	output job_t rd_data
);

	job_t mem_q [FifoDepth];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_valid && wr_ready) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_valid && wr_ready) wp_q <= ~wp_q;
			if (rd_valid && rd_ready) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
		end
	end

	property p_no_over;
		@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2;
	endproperty
	assert property (p_no_over) else $error("queue count out of range");

endmodule

/* rtl/uces_back.sv */
module uces_back import uces_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic job_valid,
	output logic job_ready,
	input  job_t job,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [ValBits-1:0] corner_emf,
	output logic [ColBits-1:0] corner_column,
	output logic [ColBits-1:0] corner_row
);

	bk_state_t st_q, st_d;
	job_t job_q;
	logic [1:0] k_q;
	logic [5:0] bit_q;
	logic signed [63:0] num_q;
	logic [63:0] mag_q, dvd_q, rem_q, quo_q;
	logic [RhoBits:0] den_q;
	logic [16:0] w_q;
	logic signed [95:0] acc_q;
	logic acc_ph_q;
	logic signed [ValBits+1:0] pa_q, pb_q;
	logic signed [ValBits-1:0] flux_c;
	logic [RhoBits:0] den_c;
	logic [GainBits-1:0] gain_c;
	logic signed [ValBits+1:0] a_c, b_c;
	logic signed [63:0] prod_c;
	logic [63:0] pmag_c;
	logic [64:0] rem_sh;
	logic [16:0] w_c;

	always_comb begin
		unique case (k_q)
			2'd0: begin flux_c = job_q.flux0; den_c = job_q.den0; gain_c = job_q.gain_x; end
			2'd1: begin flux_c = job_q.flux1; den_c = job_q.den1; gain_c = job_q.gain_x; end
			2'd2: begin flux_c = job_q.flux2; den_c = job_q.den2; gain_c = job_q.gain_y; end
			default: begin flux_c = job_q.flux3; den_c = job_q.den3; gain_c = job_q.gain_y; end
		endcase
		unique case (k_q)
			2'd0: begin
				a_c = 34'(job_q.e2i) - 34'(job_q.ca);
				b_c = 34'(job_q.e2im) - 34'(job_q.cbl);
			end
			2'd1: begin
				a_c = 34'(job_q.e2i) - 34'(job_q.cc);
				b_c = 34'(job_q.e2im) - 34'(job_q.cl);
			end
			2'd2: begin
				a_c = 34'(job_q.e1j) - 34'(job_q.cl);
				b_c = 34'(job_q.e1jm) - 34'(job_q.cbl);
			end
			default: begin
				a_c = 34'(job_q.e1j) - 34'(job_q.cc);
				b_c = 34'(job_q.e1jm) - 34'(job_q.ca);
			end
		endcase
		prod_c = 64'(signed'({1'b0, gain_c})) * 64'(flux_c);
		pmag_c = prod_c[63] ? -prod_c : prod_c;
		rem_sh = {rem_q, dvd_q[63]};
		if (num_q == '0) begin
			w_c = HalfW;
		end else if (mag_q >= {17'd0, den_q, 15'd0}) begin
			w_c = num_q[63] ? 17'd0 : OneW;
		end else if (num_q[63]) begin
			w_c = HalfW - quo_q[16:0];
		end else begin
			w_c = HalfW + quo_q[16:0];
		end
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			BK_IDLE: if (job_valid) st_d = BK_MUL;
			BK_MUL: st_d = BK_DIV;
			BK_DIV: if (bit_q == 6'd0) st_d = BK_ACC;
			BK_ACC: st_d = (k_q == 2'd3) ? BK_OUT : BK_MUL;
			BK_OUT: if (out_valid && out_ready) st_d = BK_IDLE;
			default: st_d = BK_IDLE;
		endcase
	end

	always_comb begin
		job_ready = (st_q == BK_IDLE);
		out_valid = (st_q == BK_OUT) && !acc_ph_q;
	end

	always_ff @(posedge clk) begin
		if (acc_ph_q) begin
			acc_q <= acc_q + 96'(signed'({1'b0, OneW - w_q})) * 96'(pa_q)
				+ 96'(signed'({1'b0, w_q})) * 96'(pb_q);
		end
		unique case (st_q)
			BK_IDLE: begin
				job_q <= job;
				acc_q <= (96'(job.e2im) + 96'(job.e2i) + 96'(job.e1jm) + 96'(job.e1j)) <<< 16;
			end
			BK_MUL: begin
				num_q <= prod_c;
				mag_q <= pmag_c;
				dvd_q <= pmag_c;
				den_q <= den_c;
				rem_q <= '0;
				quo_q <= '0;
				bit_q <= 6'd63;
			end
			BK_DIV: begin
				if (den_q != '0 && rem_sh >= 65'(den_q)) begin
					rem_q <= 64'(rem_sh - 65'(den_q));
					quo_q <= {quo_q[62:0], 1'b1};
				end else begin
					rem_q <= rem_sh[63:0];
					quo_q <= {quo_q[62:0], 1'b0};
				end
				dvd_q <= {dvd_q[62:0], 1'b0};
				bit_q <= bit_q - 6'd1;
			end
			BK_ACC: begin
				w_q <= w_c;
				pa_q <= a_c;
				pb_q <= b_c;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BK_IDLE;
			k_q <= 2'd0;
			acc_ph_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == BK_IDLE) k_q <= 2'd0;
			if (st_q == BK_ACC) k_q <= k_q + 2'd1;
			acc_ph_q <= (st_q == BK_ACC);
		end
	end

	assign corner_emf = sat_val(acc_q >>> 18);
	assign corner_column = job_q.col;
	assign corner_row = job_q.row;

	property p_out_hold;
		@(posedge clk) disable iff (!arst_n) out_valid && !out_ready |=> out_valid;
	endproperty
	assert property (p_out_hold) else $error("result dropped before taken");

	property p_busy;
		@(posedge clk) disable iff (!arst_n) st_q != BK_IDLE |-> !job_ready;
	endproperty
	assert property (p_busy) else $error("job taken while busy");

endmodule

/* rtl/upwind_corner_emf_stencil_core.sv */
// Upwinded corner E_z for 2D constrained transport.
// Cells enter in raster order on the s_axis channel; s_axis_tuser marks the
// first cell of a frame. Each cell with a left and a lower neighbour yields one
// transaction on m_axis carrying the saturated Q16.16 corner EMF and its
// column and row; first-row and first-column cells yield none.
// A front section works one cell at a time: product, cell EMF with line
// store read, then hand-off of a job into a two-entry queue.
// A back section works four upwind weights in turn on one shared radix-2
// divider of 64 steps, and takes no new job from the queue until its result
// has been taken. Cells that give no result hand no job to the queue.
// Configuration is written through cfg_we/cfg_addr/cfg_data; the user must
// write it only while idle, which the block itself does not enforce.
// Reset clears counters, handshakes and configuration to defaults; the line
// store is not cleared and must be written before it is read.
// A stalled m_axis holds its result; the queue then fills and s_axis_tready
// drops until the receiver takes it.
module upwind_corner_emf_stencil_core import uces_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [RegIdxBits-1:0] cfg_addr,
	input  logic [CfgBits-1:0] cfg_data,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// vel_x, vel_y, mag_x, mag_y, density, xface_flux_of_by, yface_flux_of_bx,
	// xface_mass_flux, yface_mass_flux, then zero fill.
	input  logic [287:0] s_axis_tdata,
	// start_of_frame
	input  logic s_axis_tuser,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// corner_emf, corner_column, corner_row.
	output logic [55:0] m_axis_tdata
);

	logic [12:0] row_width_q;
	logic [GainBits-1:0] gain_x_q, gain_y_q;
	logic fv, fr, bv, br;
	job_t fj, bj;
	logic signed [ValBits-1:0] emf;
	logic [ColBits-1:0] col, row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= 13'd64;
			gain_x_q <= 31'd65536;
			gain_y_q <= 31'd65536;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_ROW_WIDTH: row_width_q <= cfg_data[12:0];
				REG_GAIN_X: gain_x_q <= cfg_data;
				REG_GAIN_Y: gain_y_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	uces_front u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.sof(s_axis_tuser),
		.vel_x(s_axis_tdata[31:0]), .vel_y(s_axis_tdata[63:32]),
		.mag_x(s_axis_tdata[95:64]), .mag_y(s_axis_tdata[127:96]),
		.density(s_axis_tdata[158:128]),
		.xface_flux_of_by(s_axis_tdata[190:159]), .yface_flux_of_bx(s_axis_tdata[222:191]),
		.xface_mass_flux(s_axis_tdata[254:223]), .yface_mass_flux(s_axis_tdata[286:255]),
		.row_width(row_width_q), .gain_x(gain_x_q), .gain_y(gain_y_q),
		.job_valid(fv), .job_ready(fr), .job(fj)
	);

	uces_fifo u_fifo (
		.clk, .arst_n,
		.wr_valid(fv), .wr_ready(fr), .wr_data(fj),
		.rd_valid(bv), .rd_ready(br), .rd_data(bj)
	);

	uces_back u_back (
		.clk, .arst_n,
		.job_valid(bv), .job_ready(br), .job(bj),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.corner_emf(emf), .corner_column(col), .corner_row(row)
	);

	assign m_axis_tdata = {row, col, emf};

endmodule

/* tb/upwind_corner_emf_stencil_core_tb.sv */
`timescale 1ns / 100ps

module upwind_corner_emf_stencil_core_tb;
	import uces_pkg::*;

	typedef struct {
		bit sof;
		logic [31:0] vx, vy, bx, by;
		logic [30:0] rho;
		logic [31:0] fxb, fyb, mfx, mfy;
	} cell_in_t;

	typedef struct {
		logic [31:0] emf;
		logic [11:0] col;
		logic [11:0] row;
	} corner_t;

	typedef struct {
		longint flux_b;
		longint emf;
		longint rho;
		longint mflux;
	} stencil_ent_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [RegIdxBits-1:0] cfg_addr = '0;
	logic [CfgBits-1:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [287:0] s_axis_tdata = '0;
	logic s_axis_tuser = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [55:0] m_axis_tdata;

	upwind_corner_emf_stencil_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	cell_in_t cells_pending[$];
	corner_t corners_due[$];
	cell_in_t cell_on_bus;
	bit quiet = 1'b0;
	int errors = 0;

	stencil_ent_t line_mem[MaxRow];
	stencil_ent_t left_ent;
	stencil_ent_t below_left_ent;
	int unsigned col_cnt = 0;
	int unsigned row_cnt = 0;
	int unsigned width_reg = 64;
	longint gain_x_reg = 65536;
	longint gain_y_reg = 65536;

	function automatic longint sx(input logic [31:0] v);
		return longint'($signed(v));
	endfunction

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint upwind_w(input longint flux, input longint rlo,
			input longint rhi, input longint gain);
		longint num;
		longint den;
		longint mag;
		num = gain * flux;
		den = rlo + rhi;
		mag = (num < 0) ? -num : num;
		if (num == 0) return 32768;
		if (mag >= den * 32768) return (num > 0) ? 65536 : 0;
		return 32768 + num / den;
	endfunction

	function automatic longint mix(input longint w, input longint a, input longint b);
		return (65536 - w) * a + w * b;
	endfunction

	task automatic predict_corner(input cell_in_t c);
		int unsigned w;
		int unsigned col;
		int unsigned row;
		logic signed [127:0] prod;
		longint emf;
		longint e1j, e1jm, e2i, e2im, ca, cl, cbl;
		longint w1jm, w1j, w2im, w2i, sum;
		stencil_ent_t above;
		stencil_ent_t cx;
		stencil_ent_t cy;
		corner_t r;
		w = width_reg;
		if (w < 2) w = 2;
		if (w > MaxRow) w = MaxRow;
		if (c.sof) begin
			col_cnt = 0;
			row_cnt = 0;
		end
		col = (col_cnt < MaxRow) ? col_cnt : 0;
		row = row_cnt & 12'hfff;
		prod = sx(c.vy) * sx(c.bx) - sx(c.vx) * sx(c.by);
		prod = prod >>> 16;
		if (prod > 128'sd2147483647) emf = 64'sd2147483647;
		else if (prod < -128'sd2147483648) emf = -64'sd2147483648;
		else emf = longint'(prod);
		cx.flux_b = sx(c.fxb);
		cx.emf = emf;
		cx.rho = longint'(c.rho);
		cx.mflux = sx(c.mfx);
		cy.flux_b = sx(c.fyb);
		cy.emf = emf;
		cy.rho = cx.rho;
		cy.mflux = sx(c.mfy);
		above = line_mem[col];
		if (col >= 1 && row >= 1) begin
			e1j = -cx.flux_b;
			e1jm = -above.flux_b;
			e2i = cy.flux_b;
			e2im = left_ent.flux_b;
			ca = above.emf;
			cl = left_ent.emf;
			cbl = below_left_ent.emf;
			w1jm = upwind_w(above.mflux, below_left_ent.rho, above.rho, gain_x_reg);
			w1j = upwind_w(cx.mflux, left_ent.rho, cx.rho, gain_x_reg);
			w2im = upwind_w(left_ent.mflux, below_left_ent.rho, left_ent.rho, gain_y_reg);
			w2i = upwind_w(cy.mflux, above.rho, cy.rho, gain_y_reg);
			sum = mix(w1jm, e2i - ca, e2im - cbl) + mix(w1j, e2i - emf, e2im - cl)
				+ mix(w2im, e1j - cl, e1jm - cbl) + mix(w2i, e1j - emf, e1jm - ca)
				+ (e2im + e2i + e1jm + e1j) * 65536;
			r.emf = 32'(clamp32(sum >>> 18));
			r.col = 12'(col);
			r.row = 12'(row);
			corners_due.push_back(r);
		end
		below_left_ent.emf = above.emf;
		below_left_ent.rho = above.rho;
		below_left_ent.flux_b = 0;
		below_left_ent.mflux = 0;
		line_mem[col] = cx;
		left_ent = cy;
		if (col + 1 >= w) begin
			col_cnt = 0;
			row_cnt = (row + 1) & 12'hfff;
		end else begin
			col_cnt = col + 1;
			row_cnt = row;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) predict_corner(cell_on_bus);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (cells_pending.size() > 0 && (quiet || $urandom_range(99) >= 17)) begin
					cell_on_bus = cells_pending.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tuser <= cell_on_bus.sof;
					s_axis_tdata <= {1'b0, cell_on_bus.mfy, cell_on_bus.mfx, cell_on_bus.fyb,
						cell_on_bus.fxb, cell_on_bus.rho, cell_on_bus.by, cell_on_bus.bx,
						cell_on_bus.vy, cell_on_bus.vx};
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		corner_t exp_c;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (corners_due.size() == 0) begin
					$error("unexpected transaction: data %h", m_axis_tdata);
					errors++;
				end else begin
					exp_c = corners_due.pop_front();
					if (m_axis_tdata[31:0] !== exp_c.emf) begin
						$error("corner_emf expected %h actual %h", exp_c.emf, m_axis_tdata[31:0]);
						errors++;
					end
					if (m_axis_tdata[43:32] !== exp_c.col) begin
						$error("corner_column expected %0d actual %0d", exp_c.col,
							m_axis_tdata[43:32]);
						errors++;
					end
					if (m_axis_tdata[55:44] !== exp_c.row) begin
						$error("corner_row expected %0d actual %0d", exp_c.row,
							m_axis_tdata[55:44]);
						errors++;
					end
				end
			end
			m_axis_tready <= quiet || $urandom_range(99) >= 17;
		end
	end

	task automatic write_reg(input logic [RegIdxBits-1:0] idx, input logic [CfgBits-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		if (idx == REG_ROW_WIDTH) width_reg = val & 31'h1fff;
		else if (idx == REG_GAIN_X) gain_x_reg = longint'(val);
		else if (idx == REG_GAIN_Y) gain_y_reg = longint'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain_all();
		while (cells_pending.size() > 0 || s_axis_tvalid || corners_due.size() > 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_val();
		case ($urandom_range(9))
			0: return 32'h80000000;
			1: return 32'h7fffffff;
			2: return 32'h0;
			3, 4: return $urandom;
			default: return $urandom_range(1 << 19) - (1 << 18);
		endcase
	endfunction

	function automatic logic [30:0] pick_rho();
		case ($urandom_range(9))
			0: return 31'h0;
			1: return 31'h7fffffff;
			2: return 31'($urandom);
			default: return 31'($urandom_range(1 << 22, 1 << 14));
		endcase
	endfunction

	function automatic cell_in_t rand_cell(input bit sof);
		cell_in_t c;
		c.sof = sof;
		c.vx = pick_val();
		c.vy = pick_val();
		c.bx = pick_val();
		c.by = pick_val();
		c.rho = pick_rho();
		c.fxb = pick_val();
		c.fyb = pick_val();
		c.mfx = pick_val();
		c.mfy = pick_val();
		return c;
	endfunction

	function automatic logic [31:0] corner_val(input int k);
		case (k % 5)
			0: return 32'h80000000;
			1: return 32'h7fffffff;
			2: return 32'h0;
			3: return 32'hffffffff;
			default: return 32'h1;
		endcase
	endfunction

	function automatic logic [30:0] corner_rho(input int k);
		case (k % 4)
			0: return 31'h0;
			1: return 31'h7fffffff;
			2: return 31'h1;
			default: return 31'h10000;
		endcase
	endfunction

	function automatic logic [30:0] pick_gain();
		case ($urandom_range(5))
			0: return 31'h0;
			1: return 31'h7fffffff;
			2: return 31'd65536;
			3: return 31'($urandom);
			default: return 31'($urandom_range(1 << 20));
		endcase
	endfunction

	initial begin
		cell_in_t c;
		int n;
		int w;
		int nitems;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Extreme field values with one gain zero and the other at full scale.
		write_reg(REG_ROW_WIDTH, 31'd0);
		write_reg(REG_GAIN_X, 31'd0);
		write_reg(REG_GAIN_Y, 31'h7fffffff);
		for (int k = 0; k < 14; k++) begin
			c.sof = (k == 0);
			c.vx = corner_val(k);
			c.vy = corner_val(k + 1);
			c.bx = corner_val(k + 3);
			c.by = corner_val(k + 2);
			c.rho = corner_rho(k);
			c.fxb = corner_val(k + 4);
			c.fyb = corner_val(k + 1);
			c.mfx = corner_val(k + 2);
			c.mfy = corner_val(k + 3);
			cells_pending.push_back(c);
		end
		drain_all();

		// Zero densities: nonzero flux saturates the x weights; zero flux and the zero y gain give half weight.
		write_reg(REG_ROW_WIDTH, 31'd1);
		write_reg(REG_GAIN_X, 31'h7fffffff);
		write_reg(REG_GAIN_Y, 31'd0);
		for (int k = 0; k < 10; k++) begin
			c = rand_cell(k == 0);
			c.rho = 31'h0;
			c.mfx = (k % 3 == 0) ? 32'h0 : ((k % 3 == 1) ? 32'h5 : 32'hfffffffb);
			c.mfy = c.mfx;
			cells_pending.push_back(c);
		end
		drain_all();

		// Width above the maximum acts as the maximum: a long first row with no wrap.
		write_reg(REG_ROW_WIDTH, 31'h1fff);
		write_reg(REG_GAIN_X, 31'd65536);
		write_reg(REG_GAIN_Y, 31'd65536);
		for (int k = 0; k < 200; k++) cells_pending.push_back(rand_cell(k == 0));
		drain_all();

		// Shrinking the width mid-row wraps the column counter to the next row.
		write_reg(REG_ROW_WIDTH, 31'd3);
		for (int k = 0; k < 12; k++) cells_pending.push_back(rand_cell(1'b0));
		drain_all();

		nitems = 0;
		for (int ph = 0; nitems < 1350; ph++) begin
			case ($urandom_range(5))
				0: w = 2;
				1: w = 3;
				2: w = 5;
				3: w = $urandom_range(1);
				default: w = $urandom_range(40, 2);
			endcase
			write_reg(REG_ROW_WIDTH, 31'(w));
			write_reg(REG_GAIN_X, pick_gain());
			write_reg(REG_GAIN_Y, pick_gain());
			quiet = (ph == 4);
			n = $urandom_range(140, 60);
			for (int k = 0; k < n; k++) begin
				if (ph == 2 && k == n / 2) begin
					while (cells_pending.size() > 0 || s_axis_tvalid || corners_due.size() > 0)
						@(posedge clk);
				end
				cells_pending.push_back(rand_cell(k == 0 || $urandom_range(99) == 0));
			end
			nitems += n;
			drain_all();
		end
		quiet = 1'b0;

		if (errors == 0) begin
			$display("PASS upwind_corner_emf_stencil_core");
		end else begin
			$display("FAIL upwind_corner_emf_stencil_core");
		end
		$finish;
	end

	initial begin
		#40000000;
		$display("FAIL upwind_corner_emf_stencil_core");
		$finish;
	end

endmodule

/* upwind_corner_emf_stencil_core.f */
rtl/uces_pkg.sv
rtl/uces_front.sv
rtl/uces_fifo.sv
rtl/uces_back.sv
rtl/upwind_corner_emf_stencil_core.sv
tb/upwind_corner_emf_stencil_core_tb.sv
